### rtl/core/repeat_yoyo_timeline_sequencer_macros.svh
// assertion helpers for the timeline sequencer
`ifndef REPEAT_YOYO_TIMELINE_SEQUENCER_MACROS_SVH
`define REPEAT_YOYO_TIMELINE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define RYTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RYTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ryts_pkg.sv
package ryts_pkg;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_PAUSE  = 3'd2;
    localparam logic [2:0] MODE_RESUME = 3'd3;
    localparam logic [2:0] MODE_KILL   = 3'd4;

    localparam logic [2:0] CFG_DELAY_START   = 3'd0;
    localparam logic [2:0] CFG_ITER_DURATION = 3'd1;
    localparam logic [2:0] CFG_GAP_DELAY     = 3'd2;
    localparam logic [2:0] CFG_REPEAT_COUNT  = 3'd3;
    localparam logic [2:0] CFG_YOYO_ENABLE   = 3'd4;
    localparam logic [2:0] CFG_TRIGGER_MASK  = 3'd5;

    localparam logic [3:0] EV_STATUS        = 4'd0;
    localparam logic [3:0] EV_BEGIN         = 4'd1;
    localparam logic [3:0] EV_START         = 4'd2;
    localparam logic [3:0] EV_END           = 4'd3;
    localparam logic [3:0] EV_COMPLETE      = 4'd4;
    localparam logic [3:0] EV_BACK_BEGIN    = 4'd5;
    localparam logic [3:0] EV_BACK_START    = 4'd6;
    localparam logic [3:0] EV_BACK_END      = 4'd7;
    localparam logic [3:0] EV_BACK_COMPLETE = 4'd8;
    localparam logic [3:0] EV_SNAP_START    = 4'd9;
    localparam logic [3:0] EV_SNAP_END      = 4'd10;
    localparam logic [3:0] EV_INTERP        = 4'd11;

    localparam logic [7:0] TRIGGER_MASK_RESET = 8'd8;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] time_delta;
    } t_item;

    typedef struct packed {
        logic [3:0]         event_code;
        logic signed [31:0] step_now;
        logic signed [31:0] step_before;
        logic               in_iteration;
        logic signed [31:0] local_time;
        logic signed [31:0] part_delta;
        logic               finished;
        logic               carried;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [30:0]        delay_start;
        logic [30:0]        iter_duration;
        logic [30:0]        gap_delay;
        logic signed [15:0] repeat_count;
        logic               yoyo_enable;
        logic [7:0]         trigger_mask;
    } t_cfg;

endpackage

### rtl/core/ryts_front.sv
module ryts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ryts_pkg::t_item i_item,
    output logic           o_q_valid,
    output ryts_pkg::t_item o_q_item,
    input  logic           i_q_pop
);
    import ryts_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/ryts_seq.sv
module ryts_seq #(
    parameter int TIME_WIDTH = 32,
    parameter int MAX_EVENTS = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ryts_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  ryts_pkg::t_item   i_q_item,
    output logic              o_q_pop,
    output logic              o_out_valid,
    output ryts_pkg::t_result o_out,
    input  logic              i_out_ready
);
    import ryts_pkg::*;

    localparam int CW  = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 2;
    localparam int OCW = $clog2(MAX_EVENTS + 1);
    localparam logic signed [CW-1:0] TMAX =
        {{(CW - TIME_WIDTH + 1){1'b0}}, {(TIME_WIDTH - 1){1'b1}}};
    localparam logic signed [CW-1:0] TMIN = ~TMAX;
    localparam logic signed [CW-1:0] TZERO = '0;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_CLASS  = 7'b0000100,
        S_APPLY  = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_STATUS = 7'b1000000
    } t_state;

    typedef enum logic [2:0] {
        PH_DELAY = 3'b001,
        PH_ENTRY = 3'b010,
        PH_WALK  = 3'b100
    } t_phase;

    typedef enum logic [3:0] {
        K_DELAY, K_ENTA, K_ENTB, K_REV_IN, K_FWD_IN, K_REV_OUT, K_FWD_OUT, K_PLAY, K_WAIT
    } t_kind;

    function automatic logic signed [CW-1:0] sat(input logic signed [CW-1:0] v);
        if (v > TMAX) begin
            return TMAX;
        end else if (v < TMIN) begin
            return TMIN;
        end
        return v;
    endfunction

    function automatic logic signed [CW-1:0] sadd(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return sat(a + b);
    endfunction

    function automatic logic signed [CW-1:0] ssub(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return sat(a - b);
    endfunction

    function automatic t_result mk(input logic [3:0] code, input logic signed [31:0] stp,
                                   input logic signed [31:0] bef, input logic it,
                                   input logic signed [CW-1:0] tm,
                                   input logic signed [CW-1:0] part, input logic fin);
        t_result r;
        r.event_code   = code;
        r.step_now     = stp;
        r.step_before  = bef;
        r.in_iteration = it;
        r.local_time   = tm[31:0];
        r.part_delta   = part[31:0];
        r.finished     = fin;
        r.carried      = 1'b0;
        r.last         = 1'b0;
        return r;
    endfunction

    t_state               r_state;
    t_phase               r_phase;
    t_kind                r_kind;
    logic signed [31:0]   r_step;
    logic                 r_it;
    logic signed [CW-1:0] r_time;
    logic signed [CW-1:0] r_pend;
    logic signed [CW-1:0] r_dt;
    logic signed [CW-1:0] r_sum;
    logic signed [CW-1:0] r_part;
    logic                 r_started;
    logic                 r_init;
    logic                 r_paused;
    logic                 r_killed;
    logic                 r_fin;
    logic                 r_carry;
    logic                 r_brk;
    logic [OCW-1:0]       r_ocnt;
    t_result              r_list [3];
    logic [2:0]           r_lv;
    logic                 r_out_valid;
    t_result              r_out;

    logic signed [CW-1:0] w_sum;
    logic signed [CW-1:0] w_dur;
    logic signed [CW-1:0] w_gap;
    logic signed [CW-1:0] w_del;
    logic signed [CW-1:0] w_pz;
    logic signed [CW-1:0] w_pg;
    logic signed [CW-1:0] w_pd;
    logic signed [CW-1:0] w_pdel;
    logic signed [31:0]   w_rc2;
    logic                 w_rc_neg;
    logic                 w_valid_step;
    logic                 w_out_free;
    logic                 w_fin_out;
    logic                 w_c8;
    logic                 w_load;
    t_result              w_status;

    logic signed [31:0]   n_step;
    logic                 n_it;
    logic signed [CW-1:0] n_tfin;
    logic                 n_rev;
    t_result              n_list [3];
    logic [2:0]           n_lv;

    assign w_sum    = sadd(r_time, r_dt);
    assign w_dur    = {{(CW - 31){1'b0}}, i_cfg.iter_duration};
    assign w_gap    = {{(CW - 31){1'b0}}, i_cfg.gap_delay};
    assign w_del    = {{(CW - 31){1'b0}}, i_cfg.delay_start};
    assign w_pz     = ssub(TZERO, r_time);
    assign w_pg     = ssub(w_gap, r_time);
    assign w_pd     = ssub(w_dur, r_time);
    assign w_pdel   = ssub(w_del, r_time);
    assign w_rc2    = {{15{i_cfg.repeat_count[15]}}, i_cfg.repeat_count, 1'b0};
    assign w_rc_neg = i_cfg.repeat_count[15];
    assign w_valid_step = (!r_step[31] && r_step <= w_rc2) || w_rc_neg;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_fin_out    = r_fin || r_killed;
    assign w_load       = w_out_free &&
                          ((r_state == S_DRAIN && r_lv[0]) || r_state == S_STATUS);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;

    // closing status item
    always_comb begin
        w_status         = mk(EV_STATUS, r_step, r_step, r_it, r_time, TZERO, w_fin_out);
        w_status.carried = r_carry;
        w_status.last    = 1'b1;
    end

    // step transition and the items it emits
    always_comb begin
        n_step = r_step;
        n_it   = r_it;
        n_tfin = r_time;
        n_lv   = 3'b000;
        w_c8   = 1'b0;
        n_rev  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_list[k] = mk(EV_STATUS, r_step, r_step, r_it, r_time, TZERO, w_fin_out);
        end
        case (r_kind)
            K_DELAY, K_ENTA: begin
                n_step = '0;
                n_it   = 1'b1;
                n_tfin = TZERO;
                n_list[0] = mk(EV_BEGIN, n_step, n_step, 1'b1, TZERO, TZERO, w_fin_out);
                n_list[1] = mk(EV_START, n_step, n_step, 1'b1, TZERO, TZERO, w_fin_out);
                n_list[2] = mk(EV_INTERP, n_step, -32'sd1, 1'b1, TZERO, r_part, w_fin_out);
                n_lv = {(r_kind == K_ENTA), i_cfg.trigger_mask[1], i_cfg.trigger_mask[0]};
            end
            K_ENTB: begin
                n_step = w_rc2;
                n_it   = 1'b1;
                n_tfin = w_dur;
                n_list[0] = mk(EV_BACK_BEGIN, n_step, n_step, 1'b1, w_dur, TZERO, w_fin_out);
                n_list[1] = mk(EV_BACK_START, n_step, n_step, 1'b1, w_dur, TZERO, w_fin_out);
                n_list[2] = mk(EV_INTERP, n_step, w_rc2 + 32'sd1, 1'b1, w_dur, r_part,
                               w_fin_out);
                n_lv = {1'b1, i_cfg.trigger_mask[5], i_cfg.trigger_mask[4]};
            end
            K_REV_IN: begin
                n_step = r_step - 32'sd1;
                n_it   = 1'b1;
                n_tfin = w_dur;
                n_rev  = i_cfg.yoyo_enable && (n_step[1:0] == 2'd2);
                n_list[0] = mk(n_rev ? EV_SNAP_START : EV_SNAP_END, n_step, n_step, 1'b1,
                               w_dur, TZERO, w_fin_out);
                n_list[1] = mk(EV_BACK_START, n_step, n_step, 1'b1, w_dur, TZERO, w_fin_out);
                n_list[2] = mk(EV_INTERP, n_step, r_step, 1'b1, w_dur, r_part, w_fin_out);
                n_lv = {1'b1, i_cfg.trigger_mask[5], 1'b1};
            end
            K_FWD_IN: begin
                n_step = r_step + 32'sd1;
                n_it   = 1'b1;
                n_tfin = TZERO;
                n_rev  = i_cfg.yoyo_enable && (n_step[1:0] == 2'd2);
                n_list[0] = mk(n_rev ? EV_SNAP_END : EV_SNAP_START, n_step, n_step, 1'b1,
                               TZERO, TZERO, w_fin_out);
                n_list[1] = mk(EV_START, n_step, n_step, 1'b1, TZERO, TZERO, w_fin_out);
                n_list[2] = mk(EV_INTERP, n_step, r_step, 1'b1, TZERO, r_part, w_fin_out);
                n_lv = {1'b1, i_cfg.trigger_mask[1], 1'b1};
            end
            K_REV_OUT: begin
                n_step = r_step - 32'sd1;
                n_it   = 1'b0;
                w_c8   = n_step[31] && !w_rc_neg;
                n_tfin = w_c8 ? TZERO : w_gap;
                n_list[0] = mk(EV_INTERP, n_step, r_step, 1'b0, TZERO, r_part, w_fin_out);
                n_list[1] = mk(EV_BACK_END, n_step, n_step, 1'b0, TZERO, TZERO, w_fin_out);
                n_list[2] = mk(EV_BACK_COMPLETE, n_step, n_step, 1'b0, TZERO, TZERO,
                               w_fin_out);
                n_lv = {w_c8 && i_cfg.trigger_mask[7], i_cfg.trigger_mask[6], 1'b1};
            end
            K_FWD_OUT: begin
                n_step = r_step + 32'sd1;
                n_it   = 1'b0;
                n_tfin = TZERO;
                w_c8   = (n_step > w_rc2) && !w_rc_neg;
                n_list[0] = mk(EV_INTERP, n_step, r_step, 1'b0, w_dur, r_part, w_fin_out);
                n_list[1] = mk(EV_END, n_step, n_step, 1'b0, w_dur, TZERO, w_fin_out);
                n_list[2] = mk(EV_COMPLETE, n_step, n_step, 1'b0, w_dur, TZERO, w_fin_out);
                n_lv = {w_c8 && i_cfg.trigger_mask[3], i_cfg.trigger_mask[2], 1'b1};
            end
            K_PLAY: begin
                n_tfin = r_sum;
                n_list[0] = mk(EV_INTERP, r_step, r_step, r_it, r_sum, r_part, w_fin_out);
                n_lv = 3'b001;
            end
            default: begin
                n_tfin = r_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_DELAY;
            r_kind      <= K_WAIT;
            r_step      <= -32'sd2;
            r_it        <= 1'b0;
            r_time      <= '0;
            r_pend      <= '0;
            r_started   <= 1'b0;
            r_init      <= 1'b0;
            r_paused    <= 1'b0;
            r_killed    <= 1'b0;
            r_fin       <= 1'b0;
            r_carry     <= 1'b0;
            r_brk       <= 1'b0;
            r_ocnt      <= '0;
            r_lv        <= 3'b000;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ocnt  <= '0;
                        r_carry <= 1'b0;
                        r_state <= S_STATUS;
                        case (i_q_item.mode)
                            MODE_TICK: begin
                                if (r_started && !r_paused && !r_killed) begin
                                    r_dt    <= {{(CW - 32){i_q_item.time_delta[31]}},
                                                i_q_item.time_delta};
                                    r_state <= S_PREP;
                                end
                            end
                            MODE_START: begin
                                r_time    <= '0;
                                r_pend    <= '0;
                                r_started <= 1'b1;
                            end
                            MODE_PAUSE:  r_paused <= 1'b1;
                            MODE_RESUME: r_paused <= 1'b0;
                            MODE_KILL:   r_killed <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                S_PREP: begin
                    r_dt    <= sadd(r_pend, r_dt);
                    r_pend  <= '0;
                    r_phase <= PH_DELAY;
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_sum <= w_sum;
                    case (r_phase)
                        PH_DELAY: begin
                            if (!r_init && w_sum >= w_del) begin
                                r_kind  <= K_DELAY;
                                r_part  <= w_pdel;
                                r_state <= S_APPLY;
                            end else if (r_init) begin
                                r_phase <= PH_ENTRY;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        PH_ENTRY: begin
                            if (!r_it && !w_rc_neg && r_step[31] && !w_sum[CW-1]) begin
                                r_kind  <= K_ENTA;
                                r_part  <= w_pz;
                                r_state <= S_APPLY;
                            end else if (!r_it && !w_rc_neg && r_step > w_rc2 &&
                                         w_sum[CW-1]) begin
                                r_kind  <= K_ENTB;
                                r_part  <= w_pz;
                                r_state <= S_APPLY;
                            end else begin
                                r_phase <= PH_WALK;
                            end
                        end
                        default: begin
                            if (!w_valid_step) begin
                                r_state <= S_FIN;
                            end else if (int'(r_ocnt) + 3 > MAX_EVENTS) begin
                                r_carry <= 1'b1;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_APPLY;
                                if (!r_it && w_sum <= TZERO) begin
                                    r_kind <= K_REV_IN;
                                    r_part <= w_pz;
                                end else if (!r_it && w_sum >= w_gap) begin
                                    r_kind <= K_FWD_IN;
                                    r_part <= w_pg;
                                end else if (r_it && w_sum < TZERO) begin
                                    r_kind <= K_REV_OUT;
                                    r_part <= w_pz;
                                end else if (r_it && w_sum > w_dur) begin
                                    r_kind <= K_FWD_OUT;
                                    r_part <= w_pd;
                                end else if (r_it) begin
                                    r_kind <= K_PLAY;
                                    r_part <= r_dt;
                                end else begin
                                    r_kind <= K_WAIT;
                                end
                            end
                        end
                    endcase
                end
                S_APPLY: begin
                    r_step <= n_step;
                    r_it   <= n_it;
                    r_time <= n_tfin;
                    for (int k = 0; k < 3; k++) begin
                        r_list[k] <= n_list[k];
                    end
                    r_lv <= n_lv;
                    if (r_kind == K_PLAY || r_kind == K_WAIT) begin
                        r_dt  <= '0;
                        r_brk <= 1'b1;
                    end else begin
                        r_dt  <= ssub(r_dt, r_part);
                        r_brk <= 1'b0;
                    end
                    if (r_kind == K_DELAY) begin
                        r_init  <= 1'b1;
                        r_phase <= PH_ENTRY;
                    end else if (r_kind == K_ENTA || r_kind == K_ENTB) begin
                        r_phase <= PH_WALK;
                    end
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_lv == 3'b000) begin
                        r_state <= r_brk ? S_FIN : S_CLASS;
                    end else if (!r_lv[0] || w_out_free) begin
                        if (r_lv[0]) begin
                            r_out  <= r_list[0];
                            r_ocnt <= r_ocnt + 1'b1;
                        end
                        r_list[0] <= r_list[1];
                        r_list[1] <= r_list[2];
                        r_lv      <= {1'b0, r_lv[2:1]};
                    end
                end
                S_FIN: begin
                    if (r_init) begin
                        r_fin <= !w_rc_neg && (r_step > w_rc2 || r_step[31]);
                    end
                    if (r_carry) begin
                        r_pend <= r_dt;
                    end else begin
                        r_time <= w_sum;
                    end
                    r_state <= S_STATUS;
                end
                S_STATUS: begin
                    if (w_out_free) begin
                        r_out   <= w_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/repeat_yoyo_timeline_sequencer.sv
// timeline sequencer with start delay, repeats, gap delays and yoyo reversal
// input stream: s_axis, one transfer per command; tuser holds the mode
//   (tick, start, pause, resume, kill), tdata the signed Q16.16 tick delta
// output stream: m_axis, one transfer per event; tuser holds the event code,
//   tlast marks the status item that closes every command
// configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data; the user
//   writes only while idle, which the block itself does not enforce
// a two-entry input queue takes commands while the sequencer is busy
// a non-tick command goes from the queue to S_STATUS, which registers its status item
// a tick passes through pop, pending delta merge, a classify for each phase check,
//   step passes, finish and status; each step pass classifies, applies and then
//   drains its event slots (3 at a boundary, 1 while playing); the core handles
//   one command at a time, so throughput follows the number of events per tick
// up to MAX_EVENTS events per tick; beyond that the rest of the delta is kept
//   for the next tick and the status item has its carried bit set
// reset clears all timeline state: step -2, time 0, not started, mask 8
// when m_axis_tready is low the output register holds its transfer and the
//   sequencer waits in S_DRAIN or S_STATUS; the input queue fills and then
//   drops s_axis_tready
`include "repeat_yoyo_timeline_sequencer_macros.svh"

module repeat_yoyo_timeline_sequencer #(
    parameter int TIME_WIDTH = 32,
    parameter int MAX_EVENTS = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // time_delta
    input  logic [2:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // step_now, step_before, in_iteration, local_time, part_delta, finished,
    // carried, zero fill
    output logic [135:0] m_axis_tdata,
    output logic [3:0]   m_axis_tuser,  // event_code
    output logic         m_axis_tlast
);
    import ryts_pkg::*;

    t_cfg    r_cfg;
    t_item   w_in_item;
    t_item   w_q_item;
    logic    w_q_valid;
    logic    w_q_pop;
    t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_start   <= '0;
            r_cfg.iter_duration <= '0;
            r_cfg.gap_delay     <= '0;
            r_cfg.repeat_count  <= '0;
            r_cfg.yoyo_enable   <= 1'b0;
            r_cfg.trigger_mask  <= TRIGGER_MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY_START:   r_cfg.delay_start   <= i_cfg_data;
                CFG_ITER_DURATION: r_cfg.iter_duration <= i_cfg_data;
                CFG_GAP_DELAY:     r_cfg.gap_delay     <= i_cfg_data;
                CFG_REPEAT_COUNT:  r_cfg.repeat_count  <= i_cfg_data[15:0];
                CFG_YOYO_ENABLE:   r_cfg.yoyo_enable   <= i_cfg_data[0];
                CFG_TRIGGER_MASK:  r_cfg.trigger_mask  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_in_item.mode       = s_axis_tuser;
    assign w_in_item.time_delta = s_axis_tdata;

    ryts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    ryts_seq #(
        .TIME_WIDTH (TIME_WIDTH),
        .MAX_EVENTS (MAX_EVENTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .o_out       (w_out),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'b0, w_out.carried, w_out.finished, w_out.part_delta,
                           w_out.local_time, w_out.in_iteration, w_out.step_before,
                           w_out.step_now};
    assign m_axis_tuser = w_out.event_code;
    assign m_axis_tlast = w_out.last;

    `RYTS_ASSERT_IMP(a_last_is_status, m_axis_tvalid,
        m_axis_tlast == (m_axis_tuser == EV_STATUS), "tlast must mark the status item")
    `RYTS_ASSERT_IMP(a_carry_on_status, m_axis_tvalid && !m_axis_tlast,
        !m_axis_tdata[130], "carried set on a non-status item")
    `RYTS_ASSERT_IMP(a_before_matches, m_axis_tvalid && (m_axis_tuser != EV_INTERP),
        m_axis_tdata[63:32] == m_axis_tdata[31:0], "step_before differs outside interpolation")
    `RYTS_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output transfer changed while stalled")

endmodule
